// ===== rtl/tprr_pkg.sv =====
// tprr_pkg: types and constants of the ticket priority round-robin scheduler
// no dependencies
package tprr_pkg;

  localparam int ENTRIES = 64;
  localparam int LEVELS  = 4;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int TK_W    = 8;
  localparam int CFG_W   = 8;
  localparam logic [TK_W-1:0] TICKETS_RST = 8'd4;
  localparam logic [7:0] PERIOD_RST = 8'd40;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OC_SWITCH = 2'd0,
    OC_KEEP   = 2'd1,
    OC_HALT   = 2'd2,
    OC_STATUS = 2'd3
  } outcome_t;

  typedef enum logic {
    CMD_YIELD  = 1'b0,
    CMD_STATUS = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_TICKET_AMOUNT = 1'b0,
    REG_RESET_PERIOD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN_OLD,
    S_FIN_NEW
  } state_t;

endpackage

// ===== rtl/tprr_in_if.sv =====
// tprr_in_if: input channel, valid/ready with command payload
// depends on nothing
interface tprr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] entry_index;
  logic       ready_flag;

  modport source (output valid, cmd, entry_index, ready_flag, input ready);
  modport sink (input valid, cmd, entry_index, ready_flag, output ready);
endinterface

// ===== rtl/tprr_out_if.sv =====
// tprr_out_if: result channel, valid/ready with chosen entry and outcome
// depends on nothing
interface tprr_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] chosen_entry;
  logic [1:0] outcome;

  modport source (output valid, chosen_entry, outcome, input ready);
  modport sink (input valid, chosen_entry, outcome, output ready);
endinterface

// ===== rtl/ticket_priority_round_robin_scheduler.sv =====
// Ticket priority round-robin scheduler. A status transfer writes the table
// and is answered through the output register. A yield walks the entry table
// one entry at a time and one level per pass, each entry in two steps
// (synchronous read, then evaluate and write back on the table), and on a
// switch updates the old and new running entries in S_FIN_OLD and S_FIN_NEW.
// One item is in work at a time; no clearing pass after reset.
// depends on tprr_pkg, tprr_in_if, tprr_out_if
module ticket_priority_round_robin_scheduler
  import tprr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tprr_in_if.sink          in_ch,
  tprr_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // entry tables
  status_t                stat_mem [ENTRIES];
  logic [LVL_W+TK_W-1:0]  lt_mem   [ENTRIES];
  status_t                stat_q;
  logic [LVL_W+TK_W-1:0]  lt_q;

  state_t             state_r, state_nxt;
  logic [TK_W-1:0]    tickets_r, period_r, refill_r, refill_nxt;
  logic [7:0]         calls_r, calls_nxt;
  logic [ENTRIES-1:0] st_vld_r, st_vld_nxt, stale_r, stale_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt, start_r, start_nxt, addr_r, addr_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic               cur_vld_r, cur_vld_nxt, cur_run_r, cur_run_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt, cnt_r, cnt_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]   out_entry_r, out_entry_nxt;
  outcome_t           out_oc_r, out_oc_nxt;

  logic               st_we, lt_we;
  logic [IDX_W-1:0]   st_wa;
  status_t            st_wd;
  logic [LVL_W+TK_W-1:0] lt_wd;

  logic               acc;
  logic [7:0]         calls_inc;
  status_t            e_st;
  logic [LVL_W-1:0]   e_lvl;
  logic [TK_W-1:0]    e_tk;
  logic [IDX_W-1:0]   in_idx;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_vld_r || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign in_idx = IDX_W'(in_ch.entry_index);
  assign calls_inc = calls_r + 8'd1;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.chosen_entry = 6'(out_entry_r);
  assign out_ch.outcome      = out_oc_r;

  always_comb begin
    e_st  = st_vld_r[addr_r] ? stat_q : ST_IDLE;
    e_lvl = stale_r[addr_r] ? '0 : lt_q[LVL_W+TK_W-1:TK_W];
    e_tk  = stale_r[addr_r] ? refill_r : lt_q[TK_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    refill_nxt    = refill_r;
    calls_nxt     = calls_r;
    st_vld_nxt    = st_vld_r;
    stale_nxt     = stale_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    cur_run_nxt   = cur_run_r;
    start_nxt     = start_r;
    addr_nxt      = addr_r;
    pick_nxt      = pick_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_entry_nxt = out_entry_r;
    out_oc_nxt    = out_oc_r;
    st_we = 1'b0;
    st_wa = addr_r;
    st_wd = ST_IDLE;
    lt_we = 1'b0;
    lt_wd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_ch.cmd == CMD_STATUS) begin
            if (CNT_W'(in_ch.entry_index) < CNT_W'(ENTRIES)) begin
              st_we = 1'b1;
              st_wa = in_idx;
              st_wd = in_ch.ready_flag ? ST_READY : ST_IDLE;
              st_vld_nxt[in_idx] = 1'b1;
              if (cur_vld_r && cur_r == in_idx) cur_run_nxt = 1'b0;
            end
            out_vld_nxt   = 1'b1;
            out_entry_nxt = '0;
            out_oc_nxt    = OC_STATUS;
          end else begin
            if (calls_inc >= period_r) begin
              calls_nxt  = '0;
              stale_nxt  = '1;
              refill_nxt = tickets_r;
            end else begin
              calls_nxt = calls_inc;
            end
            if (cur_vld_r) begin
              start_nxt = (cur_r == IDX_W'(ENTRIES - 1)) ? '0 : cur_r + 1'b1;
              cnt_nxt   = CNT_W'(ENTRIES - 1);
            end else begin
              start_nxt = '0;
              cnt_nxt   = CNT_W'(ENTRIES);
            end
            addr_nxt  = cur_vld_r ? ((cur_r == IDX_W'(ENTRIES - 1)) ? '0 : cur_r + 1'b1) : '0;
            lvl_nxt   = '0;
            k_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (e_st == ST_READY && e_lvl == lvl_r &&
            (lvl_r == LVL_W'(LEVELS - 1) || e_tk != '0)) begin
          if (lvl_r != LVL_W'(LEVELS - 1)) begin
            lt_we = 1'b1;
            lt_wd = {e_lvl, e_tk - 1'b1};
            stale_nxt[addr_r] = 1'b0;
          end
          pick_nxt  = addr_r;
          state_nxt = S_FIN_OLD;
        end else begin
          if (e_st == ST_READY && e_lvl == lvl_r) begin
            lt_we = 1'b1;
            lt_wd = {lvl_r + 1'b1, tickets_r};
            stale_nxt[addr_r] = 1'b0;
          end
          state_nxt = S_RD;
          if (k_r + 1'b1 == cnt_r) begin
            if (lvl_r == LVL_W'(LEVELS - 1)) begin
              state_nxt   = S_IDLE;
              out_vld_nxt = 1'b1;
              if (cur_vld_r && cur_run_r) begin
                out_entry_nxt = cur_r;
                out_oc_nxt    = OC_KEEP;
              end else begin
                cur_vld_nxt   = 1'b0;
                cur_nxt       = '0;
                out_entry_nxt = '0;
                out_oc_nxt    = OC_HALT;
              end
            end else begin
              lvl_nxt  = lvl_r + 1'b1;
              k_nxt    = '0;
              addr_nxt = start_r;
            end
          end else begin
            k_nxt    = k_r + 1'b1;
            addr_nxt = (addr_r == IDX_W'(ENTRIES - 1)) ? '0 : addr_r + 1'b1;
          end
        end
      end
      S_FIN_OLD: begin
        if (cur_vld_r && cur_run_r) begin
          st_we = 1'b1;
          st_wa = cur_r;
          st_wd = ST_READY;
          st_vld_nxt[cur_r] = 1'b1;
        end
        state_nxt = S_FIN_NEW;
      end
      S_FIN_NEW: begin
        st_we = 1'b1;
        st_wa = pick_r;
        st_wd = ST_RUNNING;
        st_vld_nxt[pick_r] = 1'b1;
        cur_nxt       = pick_r;
        cur_vld_nxt   = 1'b1;
        cur_run_nxt   = 1'b1;
        out_vld_nxt   = 1'b1;
        out_entry_nxt = pick_r;
        out_oc_nxt    = OC_SWITCH;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // tables: synchronous read at the scan address
  always_ff @(posedge clk) begin
    if (st_we) stat_mem[st_wa] <= st_wd;
    if (lt_we) lt_mem[addr_r] <= lt_wd;
    stat_q <= stat_mem[addr_r];
    lt_q   <= lt_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tickets_r <= TICKETS_RST;
      period_r  <= PERIOD_RST;
      refill_r  <= TICKETS_RST;
      calls_r   <= 8'd1;
      st_vld_r  <= '0;
      stale_r   <= '1;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      cur_run_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      refill_r  <= refill_nxt;
      calls_r   <= calls_nxt;
      st_vld_r  <= st_vld_nxt;
      stale_r   <= stale_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      cur_run_r <= cur_run_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICKET_AMOUNT: tickets_r <= cfg_wdata;
          REG_RESET_PERIOD:  period_r  <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    addr_r      <= addr_nxt;
    pick_r      <= pick_nxt;
    lvl_r       <= lvl_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    out_entry_r <= out_entry_nxt;
    out_oc_r    <= out_oc_nxt;
  end

endmodule

// ===== tb/tprr_scoreboard.sv =====
// tprr_scoreboard: predictor and result checker for the ticket priority scheduler
// depends on tprr_pkg
`timescale 1ns / 100ps
package tprr_scoreboard_pkg;
  import tprr_pkg::*;

  typedef struct packed {
    logic [5:0] entry;
    outcome_t   outcome;
  } sched_result_t;

  class sched_scoreboard;
    logic [7:0]  tickets_cfg;
    logic [7:0]  period_cfg;
    status_t     status_tbl [ENTRIES];
    logic [1:0]  level_tbl [ENTRIES];
    logic [7:0]  ticket_tbl [ENTRIES];
    logic [5:0]  cur_idx;
    bit          cur_valid;
    logic [7:0]  yield_count;
    sched_result_t pending [$];
    int          mismatches;
    int          checked;
    int          switches, keeps, halts;

    function new();
      tickets_cfg = TICKETS_RST;
      period_cfg  = PERIOD_RST;
      for (int i = 0; i < ENTRIES; i++) begin
        status_tbl[i] = ST_IDLE;
        level_tbl[i]  = '0;
        ticket_tbl[i] = TICKETS_RST;
      end
      cur_idx = '0;
      cur_valid = 0;
      yield_count = 8'd1;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] val);
      if (idx == REG_TICKET_AMOUNT) tickets_cfg = val;
      else period_cfg = val;
    endfunction

    function int pick_next();
      int first, span, e;
      first = cur_valid ? int'(cur_idx) + 1 : 0;
      span  = cur_valid ? ENTRIES - 1 : ENTRIES;
      for (int lv = 0; lv < LEVELS; lv++) begin
        for (int k = 0; k < span; k++) begin
          e = (first + k) % ENTRIES;
          if (status_tbl[e] != ST_READY || level_tbl[e] != lv) continue;
          if (lv == LEVELS - 1) return e;
          if (ticket_tbl[e] != 0) begin
            ticket_tbl[e] = ticket_tbl[e] - 8'd1;
            return e;
          end
          level_tbl[e]  = 2'(lv + 1);
          ticket_tbl[e] = tickets_cfg;
        end
      end
      return -1;
    endfunction

    function void note_input(cmd_t cmd, logic [5:0] idx, logic rdy);
      sched_result_t r;
      int p;
      if (cmd == CMD_STATUS) begin
        status_tbl[idx] = rdy ? ST_READY : ST_IDLE;
        r.entry = '0;
        r.outcome = OC_STATUS;
        pending.push_back(r);
        return;
      end
      yield_count = yield_count + 8'd1;
      if (yield_count >= period_cfg) begin
        yield_count = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          level_tbl[i]  = '0;
          ticket_tbl[i] = tickets_cfg;
        end
      end
      p = pick_next();
      if (p >= 0) begin
        if (cur_valid && status_tbl[cur_idx] == ST_RUNNING) status_tbl[cur_idx] = ST_READY;
        status_tbl[p] = ST_RUNNING;
        cur_idx = 6'(p);
        cur_valid = 1;
        r.entry = cur_idx;
        r.outcome = OC_SWITCH;
        switches++;
      end else if (cur_valid && status_tbl[cur_idx] == ST_RUNNING) begin
        r.entry = cur_idx;
        r.outcome = OC_KEEP;
        keeps++;
      end else begin
        cur_valid = 0;
        cur_idx = '0;
        r.entry = '0;
        r.outcome = OC_HALT;
        halts++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [5:0] entry, logic [1:0] oc);
      sched_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: entry %0d outcome %0d", entry, oc);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.entry !== entry || exp_r.outcome !== oc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected entry %0d outcome %0d, got entry %0d outcome %0d",
                   exp_r.entry, exp_r.outcome, entry, oc);
      end
    endfunction
  endclass
endpackage

// ===== tb/ticket_priority_round_robin_scheduler_test.sv =====
// ticket_priority_round_robin_scheduler_test: top of the scheduler regression
// depends on tprr_pkg, tprr_in_if, tprr_out_if, tprr_scoreboard_pkg and the RTL
`timescale 1ns / 100ps
module ticket_priority_round_robin_scheduler_test;
  import tprr_pkg::*;
  import tprr_scoreboard_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  bit idle_on = 1;
  bit sink_go = 0;
  int sent = 0;

  tprr_in_if in_ch ();
  tprr_out_if out_ch ();

  sched_scoreboard sb;

  ticket_priority_round_robin_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = 0;
    in_ch.entry_index = '0;
    in_ch.ready_flag = 0;
    out_ch.ready = 0;
  end

  // result side, with random stall bursts
  always @(posedge clk) begin
    if (sink_go && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.chosen_entry, out_ch.outcome);
  end

  initial begin
    int gap;
    wait (sink_go);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  task automatic send_item(cmd_t cmd, logic [5:0] idx, logic rdy);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.entry_index <= idx;
    in_ch.ready_flag <= rdy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, idx, rdy);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6)
        send_item(CMD_STATUS, 6'($urandom_range(0, 63)), $urandom_range(0, 3) != 0);
      else
        send_item(CMD_YIELD, 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    sink_go = 1;

    // directed: empty table, extremes, current entry overwrite
    send_item(CMD_YIELD, 6'd0, 0);
    send_item(CMD_STATUS, 6'd0, 1);
    send_item(CMD_STATUS, 6'd63, 1);
    send_item(CMD_YIELD, 6'd63, 1);
    send_item(CMD_YIELD, 6'd0, 0);
    send_item(CMD_YIELD, 6'd0, 0);
    send_item(CMD_STATUS, 6'd0, 0);
    send_item(CMD_YIELD, 6'd0, 0);
    send_item(CMD_STATUS, 6'd63, 0);
    send_item(CMD_YIELD, 6'd0, 0);
    send_item(CMD_STATUS, 6'd42, 1);
    for (int i = 0; i < 8; i++) send_item(CMD_YIELD, 6'd0, 0);
    drain();

    write_reg(REG_TICKET_AMOUNT, 8'd0);
    write_reg(REG_RESET_PERIOD, 8'd0);
    random_phase(150);
    drain();
    write_reg(REG_TICKET_AMOUNT, 8'd255);
    write_reg(REG_RESET_PERIOD, 8'd255);
    random_phase(150);
    drain();
    write_reg(REG_TICKET_AMOUNT, 8'd1);
    write_reg(REG_RESET_PERIOD, 8'd1);
    random_phase(100);
    drain();
    write_reg(REG_TICKET_AMOUNT, 8'($urandom_range(0, 255)));
    write_reg(REG_RESET_PERIOD, 8'($urandom_range(1, 255)));
    random_phase(100);
    idle_on = 0;
    random_phase(80);
    drain();

    $display("covered %0d items: %0d switches, %0d keeps, %0d halts, %0d results checked",
             sent, sb.switches, sb.keeps, sb.halts, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("ticket_priority_round_robin_scheduler regression: pass");
    else
      $display("ticket_priority_round_robin_scheduler regression: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("ticket_priority_round_robin_scheduler regression: fail");
    $finish;
  end
endmodule
